@@ hw/rtl/tvd_pkg.sv @@
package tvd_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 256;
  localparam int COORD_W             = 32;
  localparam int INDEX_W             = 8;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] az;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [COORD_W-1:0] bz;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
  } tri_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index_a;
    logic [INDEX_W-1:0] index_b;
    logic [INDEX_W-1:0] index_c;
    logic               new_a;
    logic               new_b;
    logic               new_c;
    logic               overflow;
  } tri_out_t;

  // Lookup probe that walks the cell row.
  typedef struct packed {
    logic    valid;
    logic    found;
    vertex_t vertex;
  } probe_t;

  // Float equality on raw patterns: +0 == -0, NaN equals nothing.
  function automatic logic coord_eq(input logic [COORD_W-1:0] p,
                                    input logic [COORD_W-1:0] q);
    logic p_nan;
    logic q_nan;
    logic both_zero;
    p_nan     = p[COORD_W-2:0] > 31'h7F80_0000;
    q_nan     = q[COORD_W-2:0] > 31'h7F80_0000;
    both_zero = (p[COORD_W-2:0] == '0) && (q[COORD_W-2:0] == '0);
    return !p_nan && !q_nan && (both_zero || (p == q));
  endfunction

  function automatic logic vertex_eq(input vertex_t p, input vertex_t q);
    return coord_eq(p.x, q.x) && coord_eq(p.y, q.y) && coord_eq(p.z, q.z);
  endfunction

endpackage

@@ hw/rtl/triangle_vertex_dedup.sv @@
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | in_data  (tvd_pkg::tri_in_t)
// out     | output    | out_valid / out_ready | out_data (tvd_pkg::tri_out_t)
//
// Each triangle goes through these steps: three probes enter the cell row one after
// another and each walks all TABLE_DEPTH cells, one cell per cycle; then three
// insert steps, and then the result register is loaded.
// Reset (rst, synchronous) empties the table by clearing the vertex count.
// A finished result waits in the output register; the next request is taken
// meanwhile, and only its completion stalls until the register is free.
module triangle_vertex_dedup #(
  parameter int TABLE_DEPTH = tvd_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tvd_pkg::tri_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tvd_pkg::tri_out_t out_data
);
  import tvd_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FEED = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_INS  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]       state;
  logic [1:0]       sel;
  logic [1:0]       rcv;
  logic [CNT_W-1:0] count;
  tri_in_t          req_q;
  logic [2:0]       found_q;
  logic [IDX_W-1:0] idx_q [3];
  logic [2:0]       new_q;
  logic             ovf_q;
  vertex_t          cur_vtx;
  logic             wr_en;
  logic             full;
  logic             load_out;

  probe_t           probe [TABLE_DEPTH+1];
  logic [IDX_W-1:0] pidx  [TABLE_DEPTH+1];

  always_comb begin
    case (sel)
      2'd0:    cur_vtx = '{x: req_q.ax, y: req_q.ay, z: req_q.az};
      2'd1:    cur_vtx = '{x: req_q.bx, y: req_q.by, z: req_q.bz};
      default: cur_vtx = '{x: req_q.cx, y: req_q.cy, z: req_q.cz};
    endcase
  end

  assign in_ready = (state == ST_IDLE);
  assign full     = (count == CNT_W'(TABLE_DEPTH));
  assign wr_en    = (state == ST_INS) && !found_q[sel] && !full;
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  assign probe[0] = '{valid: (state == ST_FEED), found: 1'b0, vertex: cur_vtx};
  assign pidx[0]  = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    tvd_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (wr_en),
      .wr_idx    (count[IDX_W-1:0]),
      .wr_vertex (cur_vtx),
      .count     (count),
      .probe_in  (probe[i]),
      .idx_in    (pidx[i]),
      .probe_out (probe[i+1]),
      .idx_out   (pidx[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sel       <= 2'd0;
      rcv       <= 2'd0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // Collect lookup results as probes leave the last cell.
      if (probe[TABLE_DEPTH].valid) begin
        found_q[rcv] <= probe[TABLE_DEPTH].found;
        idx_q[rcv]   <= pidx[TABLE_DEPTH];
        rcv          <= (rcv == 2'd2) ? 2'd0 : rcv + 2'd1;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_q <= in_data;
            new_q <= 3'b000;
            ovf_q <= 1'b0;
            sel   <= 2'd0;
            state <= ST_FEED;
          end
        end
        ST_FEED: begin
          if (sel == 2'd2) begin
            sel   <= 2'd0;
            state <= ST_WAIT;
          end else begin
            sel <= sel + 2'd1;
          end
        end
        ST_WAIT: begin
          if (probe[TABLE_DEPTH].valid && (rcv == 2'd2)) begin
            state <= ST_INS;
          end
        end
        ST_INS: begin
          if (!found_q[sel]) begin
            if (!full) begin
              idx_q[sel] <= count[IDX_W-1:0];
              new_q[sel] <= 1'b1;
              count      <= count + CNT_W'(1);
            end else begin
              idx_q[sel] <= '0;
              ovf_q      <= 1'b1;
            end
          end
          if (sel == 2'd2) begin
            sel   <= 2'd0;
            state <= ST_DONE;
          end else begin
            sel <= sel + 2'd1;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_data.index_a  <= INDEX_W'(idx_q[0]);
            out_data.index_b  <= INDEX_W'(idx_q[1]);
            out_data.index_c  <= INDEX_W'(idx_q[2]);
            out_data.new_a    <= new_q[0];
            out_data.new_b    <= new_q[1];
            out_data.new_c    <= new_q[2];
            out_data.overflow <= ovf_q;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("vertex count beyond table depth");

  a_idle_no_probe: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !probe[TABLE_DEPTH].valid)
    else $error("lookup still in flight while taking a request");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not advance the vertex count");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.overflow) |-> full)
    else $error("overflow reported with room left in the table");

endmodule

@@ hw/rtl/tvd_cell.sv @@
module tvd_cell #(
  parameter int IDX_W    = 8,
  parameter int CNT_W    = 9,
  parameter int CELL_IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_idx,
  input  tvd_pkg::vertex_t      wr_vertex,
  input  logic [CNT_W-1:0]      count,
  input  tvd_pkg::probe_t       probe_in,
  input  logic [IDX_W-1:0]      idx_in,
  output tvd_pkg::probe_t       probe_out,
  output logic [IDX_W-1:0]      idx_out
);
  import tvd_pkg::*;

  vertex_t          entry;
  logic             occupied;
  logic             hit;
  logic             valid;
  logic             found;
  vertex_t          vertex;
  logic [IDX_W-1:0] idx;

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IDX_W'(CELL_IDX))) begin
      entry <= wr_vertex;
    end
  end

  assign occupied = CNT_W'(CELL_IDX) < count;
  assign hit      = probe_in.valid && occupied && vertex_eq(probe_in.vertex, entry);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= probe_in.valid;
    end
  end

  // Later cells hold newer entries, so a hit here overrides earlier ones.
  always_ff @(posedge clk) begin
    vertex <= probe_in.vertex;
    found  <= probe_in.found | hit;
    idx    <= hit ? IDX_W'(CELL_IDX) : idx_in;
  end

  assign probe_out = '{valid: valid, found: found, vertex: vertex};
  assign idx_out   = idx;

endmodule
